// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the list RTL.
// Needs a clock i_clk and an active-low reset i_rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ili_pkg.sv =====
// Package for the positional list: opcodes, status codes, cell command.
// No dependencies.
package ili_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int CAPACITY_MAX = 1024;
    localparam int POS_W_MAX    = $clog2(CAPACITY_MAX + 1);
    localparam int VAL_W        = 32;
    localparam int OP_W         = 3;
    localparam int ST_W         = 2;
    localparam int GRP_W        = 8;

    localparam logic [VAL_W-1:0] RD_MISS = {VAL_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_GET      = 3'd0,
        OP_ADD_HEAD = 3'd1,
        OP_ADD_TAIL = 3'd2,
        OP_INSERT   = 3'd3,
        OP_DELETE   = 3'd4
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } t_state;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic                 ins;
        logic                 del;
        logic [POS_W_MAX-1:0] pos;
        logic [VAL_W-1:0]     val;
    } t_cell_cmd;

endpackage

// ===== hw/rtl/ili_cell.sv =====
// One slot of the list chain: holds a value, shifts with its neighbours.
// Depends on ili_pkg.
module ili_cell
    import ili_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic             i_clk,
    input  t_cell_cmd        i_cmd,
    input  logic [VAL_W-1:0] i_left,
    input  logic [VAL_W-1:0] i_right,
    output logic [VAL_W-1:0] o_value,
    output logic [VAL_W-1:0] o_rd
);

    localparam logic [POS_W_MAX-1:0] IDX_C = POS_W_MAX'(IDX);

    logic [VAL_W-1:0] r_value;
    logic [VAL_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        if (i_cmd.ins) begin
            if (IDX_C > i_cmd.pos) begin
                n_value = i_left;
            end else if (IDX_C == i_cmd.pos) begin
                n_value = i_cmd.val;
            end
        end else if (i_cmd.del) begin
            if (IDX_C >= i_cmd.pos) begin
                n_value = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_rd    = (IDX_C == i_cmd.pos) ? r_value : '0;

endmodule

// ===== hw/rtl/ili_ctrl.sv =====
// Request sequencer: decode, length and status, result register.
// Depends on ili_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ili_ctrl
    import ili_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int POS_W    = $clog2(CAPACITY + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_valid,
    output logic             o_s_ready,
    input  logic [OP_W-1:0]  i_opcode,
    input  logic [POS_W-1:0] i_position,
    input  logic [VAL_W-1:0] i_item_value,
    output logic             o_m_valid,
    input  logic             i_m_ready,
    output logic [VAL_W-1:0] o_read_value,
    output logic [ST_W-1:0]  o_status,
    output logic [POS_W-1:0] o_list_length,
    output t_cell_cmd        o_cmd,
    input  logic [VAL_W-1:0] i_rd_value
);

    localparam logic [POS_W-1:0] CAP_C = POS_W'(CAPACITY);

    t_state           r_state;
    t_state           n_state;
    t_opcode          r_op;
    logic [POS_W-1:0] r_pos;
    logic [VAL_W-1:0] r_val;
    logic [POS_W-1:0] r_count;
    t_status          r_st;
    logic             r_is_get;
    logic             r_get_ok;
    logic             r_m_valid;
    logic [VAL_W-1:0] r_m_rd;
    t_status          r_m_st;
    logic [POS_W-1:0] r_m_len;

    t_status          n_st;
    logic             w_ins;
    logic             w_del;
    logic [POS_W-1:0] w_epos;
    logic             w_get_ok;
    logic             w_full;
    logic             w_accept;
    logic             w_exec;
    logic             w_load_out;

    // Decode of the held request against the current length.
    always_comb begin
        n_st     = ST_DONE;
        w_ins    = 1'b0;
        w_del    = 1'b0;
        w_epos   = r_pos;
        w_get_ok = 1'b0;
        w_full   = (r_count == CAP_C);
        case (r_op)
            OP_GET: begin
                if (r_pos < r_count) begin
                    w_get_ok = 1'b1;
                end else begin
                    n_st = ST_RANGE;
                end
            end
            OP_ADD_HEAD: begin
                w_epos = '0;
                if (w_full) begin
                    n_st = ST_FULL;
                end else begin
                    w_ins = 1'b1;
                end
            end
            OP_ADD_TAIL: begin
                w_epos = r_count;
                if (w_full) begin
                    n_st = ST_FULL;
                end else begin
                    w_ins = 1'b1;
                end
            end
            OP_INSERT: begin
                if (r_pos > r_count) begin
                    n_st = ST_RANGE;
                end else if (w_full) begin
                    n_st = ST_FULL;
                end else begin
                    w_ins = 1'b1;
                end
            end
            OP_DELETE: begin
                if (r_pos >= r_count) begin
                    n_st = ST_RANGE;
                end else begin
                    w_del = 1'b1;
                end
            end
            default: begin
                n_st = ST_RANGE;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_READ;
            end
            S_READ: begin
                if (!r_m_valid || i_m_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_ready  = (r_state == S_IDLE);
        w_exec     = (r_state == S_EXEC);
        w_load_out = (r_state == S_READ) && (!r_m_valid || i_m_ready);
        w_accept   = o_s_ready && i_s_valid;
        o_cmd.ins  = w_exec && w_ins;
        o_cmd.del  = w_exec && w_del;
        o_cmd.pos  = POS_W_MAX'(w_epos);
        o_cmd.val  = r_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.ins) begin
                r_count <= r_count + POS_W'(1);
            end else if (o_cmd.del) begin
                r_count <= r_count - POS_W'(1);
            end
            if (w_load_out) begin
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= t_opcode'(i_opcode);
            r_pos <= i_position;
            r_val <= i_item_value;
        end
        if (w_exec) begin
            r_st     <= n_st;
            r_is_get <= (r_op == OP_GET);
            r_get_ok <= w_get_ok;
        end
        if (w_load_out) begin
            r_m_rd  <= r_is_get ? (r_get_ok ? i_rd_value : RD_MISS) : '0;
            r_m_st  <= r_st;
            r_m_len <= r_count;
        end
    end

    assign o_m_valid     = r_m_valid;
    assign o_read_value  = r_m_rd;
    assign o_status      = r_m_st;
    assign o_list_length = r_m_len;

    `ASSERT_ALWAYS(a_count_bound, r_count <= CAP_C, "length above capacity")
    `ASSERT_ALWAYS(a_cmd_in_exec, !(o_cmd.ins || o_cmd.del) || w_exec, "shift outside exec")
    `ASSERT_NEXT(a_ins_grows, o_cmd.ins, r_count == $past(r_count) + POS_W'(1), "insert miscount")

endmodule

// ===== hw/rtl/indexed_list_insert_delete.sv =====
// Top level of the positional list: cell chain, read-out OR tree, sequencer.
// Depends on ili_pkg, ili_cell and ili_ctrl.
//
//  channel  dir  tdata (low bit up)                  tuser
//  s_axis   in   position, item_value, zero pad      opcode
//  m_axis   out  read_value, list_length, zero pad   status
//
// Each request goes through capture, a shift of the whole cell chain in
// parallel with the grouped OR read-out, then the final OR into the result
// register. The read tree has two levels, of which the first is registered.
// A stalled result holds in the output register; the next request is taken
// meanwhile and waits in its last step. Synchronous active-low reset clears
// the length; cell contents are not reset.
module indexed_list_insert_delete
    import ili_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int POS_W     = $clog2(CAPACITY + 1),
    parameter int S_TDATA_W = ((POS_W + VAL_W + 7) / 8) * 8,
    parameter int M_TDATA_W = ((VAL_W + POS_W + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,  // position, item_value
    input  logic [OP_W-1:0]      i_s_axis_tuser,  // opcode
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,  // read_value, list_length
    output logic [ST_W-1:0]      o_m_axis_tuser   // status
);

    localparam int NGRP = (CAPACITY + GRP_W - 1) / GRP_W;

    t_cell_cmd        w_cmd;
    logic [VAL_W-1:0] w_value [CAPACITY];
    logic [VAL_W-1:0] w_left  [CAPACITY];
    logic [VAL_W-1:0] w_right [CAPACITY];
    logic [VAL_W-1:0] w_rd    [NGRP*GRP_W];
    logic [VAL_W-1:0] r_grp   [NGRP];
    logic [VAL_W-1:0] w_rd_value;
    logic [VAL_W-1:0] w_read_value;
    logic [POS_W-1:0] w_list_length;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign w_left[i] = '0;
        end else begin : g_mid
            assign w_left[i] = w_value[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign w_right[i] = w_value[i];
        end else begin : g_inner
            assign w_right[i] = w_value[i+1];
        end
        ili_cell #(
            .IDX(i)
        ) u_cell (
            .i_clk  (i_clk),
            .i_cmd  (w_cmd),
            .i_left (w_left[i]),
            .i_right(w_right[i]),
            .o_value(w_value[i]),
            .o_rd   (w_rd[i])
        );
    end

    for (genvar i = CAPACITY; i < NGRP * GRP_W; i++) begin : g_pad
        assign w_rd[i] = '0;
    end

    for (genvar g = 0; g < NGRP; g++) begin : g_grp
        logic [VAL_W-1:0] n_grp;
        always_comb begin
            n_grp = '0;
            for (int j = 0; j < GRP_W; j++) begin
                n_grp = n_grp | w_rd[g*GRP_W+j];
            end
        end
        always_ff @(posedge i_clk) begin
            r_grp[g] <= n_grp;
        end
    end

    always_comb begin
        w_rd_value = '0;
        for (int g = 0; g < NGRP; g++) begin
            w_rd_value = w_rd_value | r_grp[g];
        end
    end

    ili_ctrl #(
        .CAPACITY(CAPACITY),
        .POS_W   (POS_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_valid    (i_s_axis_tvalid),
        .o_s_ready    (o_s_axis_tready),
        .i_opcode     (i_s_axis_tuser),
        .i_position   (i_s_axis_tdata[POS_W-1:0]),
        .i_item_value (i_s_axis_tdata[POS_W+VAL_W-1:POS_W]),
        .o_m_valid    (o_m_axis_tvalid),
        .i_m_ready    (i_m_axis_tready),
        .o_read_value (w_read_value),
        .o_status     (o_m_axis_tuser),
        .o_list_length(w_list_length),
        .o_cmd        (w_cmd),
        .i_rd_value   (w_rd_value)
    );

    assign o_m_axis_tdata = M_TDATA_W'({w_list_length, w_read_value});

endmodule

// ===== bench/tb_indexed_list_insert_delete.sv =====
// Self-checking bench for indexed_list_insert_delete: directed table, then random requests.
// Every result beat is checked against the table's expected answer or a queue-based predictor of the list.
// Depends on ili_pkg and the RTL of indexed_list_insert_delete.
module tb_indexed_list_insert_delete
    import ili_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POS_W          = $clog2(CAPACITY_DEF + 1);
    localparam int S_TDATA_W      = ((POS_W + VAL_W + 7) / 8) * 8;
    localparam int M_TDATA_W      = ((VAL_W + POS_W + 7) / 8) * 8;
    localparam int RANDOM_ITEMS   = 1130;
    localparam int TAIL_CYCLES    = 12;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DIR_N          = 23;

    localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

    typedef enum {PH_FILL, PH_DRAIN, PH_MIX} t_phase;
    typedef enum {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_SPARSE} t_rx_mode;

    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        logic [ST_W-1:0]  status;
        logic [POS_W-1:0] list_length;
    } t_answer;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        logic             known;
        t_answer          want;
    } t_req_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata = '0;
    logic [OP_W-1:0]      i_s_axis_tuser = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;
    logic [ST_W-1:0]      o_m_axis_tuser;

    logic [VAL_W-1:0] held_values [$];
    t_answer          pending_answers [$];
    int unsigned      mismatches = 0;
    int unsigned      beats_seen = 0;
    int unsigned      burst_left = 0;
    bit               gaps_on = 1'b1;
    int unsigned      rx_cycle = 0;
    t_rx_mode         rx_mode = RX_OPEN;
    t_req_row         dir_rows [DIR_N];

    indexed_list_insert_delete dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),  // position, item_value
        .i_s_axis_tuser  (i_s_axis_tuser),  // opcode
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // read_value, list_length
        .o_m_axis_tuser  (o_m_axis_tuser)   // status
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [OP_W-1:0] pick_reserved();
        case ($urandom_range(0, 2))
            0:       return OP_RSVD_5;
            1:       return OP_RSVD_6;
            default: return OP_RSVD_7;
        endcase
    endfunction

    function automatic t_answer apply_request(input logic [OP_W-1:0] op,
                                              input logic [POS_W-1:0] pos,
                                              input logic [VAL_W-1:0] val);
        t_answer     a;
        int unsigned n;
        n = held_values.size();
        a = '0;
        a.status = ST_DONE;
        case (op)
            OP_GET: begin
                if (pos < n) begin
                    a.read_value = held_values[pos];
                end else begin
                    a.read_value = RD_MISS;
                    a.status = ST_RANGE;
                end
            end
            OP_ADD_HEAD: begin
                if (n >= CAPACITY_DEF) a.status = ST_FULL;
                else held_values.push_front(val);
            end
            OP_ADD_TAIL: begin
                if (n >= CAPACITY_DEF) a.status = ST_FULL;
                else held_values.push_back(val);
            end
            OP_INSERT: begin
                if (pos > n) a.status = ST_RANGE;
                else if (n >= CAPACITY_DEF) a.status = ST_FULL;
                else held_values.insert(int'(pos), val);
            end
            OP_DELETE: begin
                if (pos >= n) a.status = ST_RANGE;
                else held_values.delete(int'(pos));
            end
            default: begin
                a.status = ST_RANGE;
            end
        endcase
        a.list_length = POS_W'(held_values.size());
        return a;
    endfunction

    // Present one request and return at the edge where it is taken.
    task automatic present(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic [VAL_W-1:0] val);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = gaps_on ? $urandom_range(0, 5) : 0;
            if (gap != 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= S_TDATA_W'({val, pos});
        i_s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    task automatic report(input string what, input t_answer want, input t_answer got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s at beat %0d: want rd %h st %0d len %0d, got rd %h st %0d len %0d",
                     what, beats_seen, want.read_value, want.status, want.list_length,
                     got.read_value, got.status, got.list_length);
        end
    endtask

    // Result side: tready follows one of four stall patterns, picked anew at random.
    always @(posedge i_clk) begin
        rx_cycle = rx_cycle + 1;
        if (rx_cycle % 256 == 0) rx_mode = t_rx_mode'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:    i_m_axis_tready <= 1'b1;
            RX_RANDOM:  i_m_axis_tready <= ($urandom_range(0, 3) != 0);
            RX_PATTERN: i_m_axis_tready <= (rx_cycle % 7 < 4);
            default:    i_m_axis_tready <= ($urandom_range(0, 9) < 3);
        endcase
    end

    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.read_value  = o_m_axis_tdata[VAL_W-1:0];
            got.list_length = o_m_axis_tdata[VAL_W +: POS_W];
            got.status      = o_m_axis_tuser;
            if (pending_answers.size() == 0) begin
                report("unexpected beat", '0, got);
            end else begin
                want = pending_answers.pop_front();
                if (got != want) report("mismatch", want, got);
            end
            beats_seen++;
        end
    end

    initial begin
        int unsigned idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                idle = 0;
            else
                idle++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        t_answer          got;
        t_phase           phase;
        int unsigned      sent;
        int unsigned      phase_len;
        int unsigned      n;
        int unsigned      r;
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;

        dir_rows = '{
            '{OP_GET,      7'd0,   32'h0,        1'b1, '{RD_MISS,      ST_RANGE, 7'd0}},
            '{OP_DELETE,   7'd0,   32'h0,        1'b1, '{32'h0,        ST_RANGE, 7'd0}},
            '{OP_INSERT,   7'd1,   32'h1234,     1'b1, '{32'h0,        ST_RANGE, 7'd0}},
            '{OP_GET,      7'd127, 32'h0,        1'b1, '{RD_MISS,      ST_RANGE, 7'd0}},
            '{OP_INSERT,   7'd0,   32'h7FFFFFFF, 1'b1, '{32'h0,        ST_DONE,  7'd1}},
            '{OP_ADD_HEAD, 7'd127, 32'h80000000, 1'b1, '{32'h0,        ST_DONE,  7'd2}},
            '{OP_ADD_TAIL, 7'd64,  32'h0,        1'b1, '{32'h0,        ST_DONE,  7'd3}},
            '{OP_ADD_TAIL, 7'd0,   32'hFFFFFFFF, 1'b1, '{32'h0,        ST_DONE,  7'd4}},
            '{OP_INSERT,   7'd4,   32'h55555555, 1'b1, '{32'h0,        ST_DONE,  7'd5}},
            '{OP_INSERT,   7'd6,   32'h1,        1'b1, '{32'h0,        ST_RANGE, 7'd5}},
            '{OP_INSERT,   7'd2,   32'hAAAAAAAA, 1'b1, '{32'h0,        ST_DONE,  7'd6}},
            '{OP_GET,      7'd0,   32'hFFFFFFFF, 1'b1, '{32'h80000000, ST_DONE,  7'd6}},
            '{OP_GET,      7'd5,   32'h0,        1'b0, '0},
            '{OP_GET,      7'd6,   32'h0,        1'b1, '{RD_MISS,      ST_RANGE, 7'd6}},
            '{OP_RSVD_5,   7'd3,   32'h1,        1'b1, '{32'h0,        ST_RANGE, 7'd6}},
            '{OP_RSVD_6,   7'd0,   32'hFFFFFFFF, 1'b1, '{32'h0,        ST_RANGE, 7'd6}},
            '{OP_RSVD_7,   7'd127, 32'h80000000, 1'b1, '{32'h0,        ST_RANGE, 7'd6}},
            '{OP_DELETE,   7'd6,   32'h0,        1'b1, '{32'h0,        ST_RANGE, 7'd6}},
            '{OP_DELETE,   7'd0,   32'h0,        1'b0, '0},
            '{OP_DELETE,   7'd4,   32'h0,        1'b0, '0},
            '{OP_GET,      7'd2,   32'h0,        1'b0, '0},
            '{OP_DELETE,   7'd64,  32'h0,        1'b1, '{32'h0,        ST_RANGE, 7'd4}},
            '{OP_GET,      7'd64,  32'h0,        1'b1, '{RD_MISS,      ST_RANGE, 7'd4}}
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            present(dir_rows[i].op, dir_rows[i].pos, dir_rows[i].val);
            got = apply_request(dir_rows[i].op, dir_rows[i].pos, dir_rows[i].val);
            pending_answers.push_back(dir_rows[i].known ? dir_rows[i].want : got);
        end

        // Fill phases push the list toward the full case, drain phases toward empty.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            phase = t_phase'($urandom_range(0, 2));
            phase_len = (phase == PH_FILL) ? $urandom_range(60, 160) : $urandom_range(40, 120);
            gaps_on = ($urandom_range(0, 3) != 0);
            for (int unsigned j = 0; j < phase_len && sent < RANDOM_ITEMS; j++) begin
                n = held_values.size();
                r = $urandom_range(0, 99);
                case (phase)
                    PH_FILL: begin
                        if (r < 20) op = OP_ADD_HEAD;
                        else if (r < 40) op = OP_ADD_TAIL;
                        else if (r < 70) op = OP_INSERT;
                        else if (r < 85) op = OP_GET;
                        else if (r < 97) op = OP_DELETE;
                        else op = pick_reserved();
                    end
                    PH_DRAIN: begin
                        if (r < 5) op = OP_ADD_HEAD;
                        else if (r < 10) op = OP_ADD_TAIL;
                        else if (r < 20) op = OP_INSERT;
                        else if (r < 45) op = OP_GET;
                        else if (r < 98) op = OP_DELETE;
                        else op = pick_reserved();
                    end
                    default: begin
                        if (r < 10) op = OP_ADD_HEAD;
                        else if (r < 20) op = OP_ADD_TAIL;
                        else if (r < 40) op = OP_INSERT;
                        else if (r < 70) op = OP_GET;
                        else if (r < 98) op = OP_DELETE;
                        else op = pick_reserved();
                    end
                endcase
                r = $urandom_range(0, 9);
                if (r == 0) pos = POS_W'($urandom_range(0, 127));
                else if (r == 1) pos = POS_W'(n);
                else if (r == 2 && n != 0) pos = POS_W'(n - 1);
                else pos = POS_W'($urandom_range(0, n));
                r = $urandom_range(0, 9);
                case (r)
                    0:       val = 32'h80000000;
                    1:       val = 32'h7FFFFFFF;
                    2:       val = 32'hFFFFFFFF;
                    3:       val = 32'h0;
                    default: val = $urandom;
                endcase
                present(op, pos, val);
                pending_answers.push_back(apply_request(op, pos, val));
                sent++;
            end
        end

        i_s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ili_pkg.sv
hw/rtl/ili_cell.sv
hw/rtl/ili_ctrl.sv
hw/rtl/indexed_list_insert_delete.sv
bench/tb_indexed_list_insert_delete.sv
